FILE: src/mcdt_pkg.sv
package mcdt_pkg;

  localparam int OP_W    = 2;
  localparam int CHAN_W  = 4;
  localparam int DELAY_W = 16;
  localparam int RES_W   = 2;

  // operation codes on the request channel
  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_START  = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

  // event codes on the event channel
  localparam logic [RES_W-1:0] EV_EXPIRED   = 2'd0;
  localparam logic [RES_W-1:0] EV_BLOCK_REQ = 2'd1;
  localparam logic [RES_W-1:0] EV_BLOCK_REL = 2'd2;
  localparam logic [RES_W-1:0] EV_BAD       = 2'd3;

  typedef enum logic [1:0] {
    CMD_EXPIRE,
    CMD_START,
    CMD_CANCEL
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // broadcast to every cell for the duration of one scan
  typedef struct packed {
    cmd_t mode;
    logic notify;
    logic blocking;
  } cell_cmd_t;

  // what a cell shows to the sequencer
  typedef struct packed {
    logic live;
    logic blocking;
    logic pend;
    logic pend_block;
    logic pend_flag;
  } cell_stat_t;

endpackage

FILE: src/mcdt_req_if.sv
interface mcdt_req_if;
  logic                        valid;
  logic                        ready;
  logic [mcdt_pkg::OP_W-1:0]   operation;
  logic [mcdt_pkg::CHAN_W-1:0] channel;
  logic [mcdt_pkg::DELAY_W-1:0] delay_ms;
  logic                        notify;
  logic                        blocking;

  modport source (output valid, operation, channel, delay_ms, notify, blocking, input ready);
  modport sink (input valid, operation, channel, delay_ms, notify, blocking, output ready);
endinterface

FILE: src/mcdt_evt_if.sv
interface mcdt_evt_if;
  logic                        valid;
  logic                        ready;
  logic [mcdt_pkg::RES_W-1:0]  event_res;
  logic [mcdt_pkg::CHAN_W-1:0] event_channel;
  logic                        raise_flag;
  logic                        still_running;
  logic                        last_event;

  modport source (output valid, event_res, event_channel, raise_flag, still_running,
                  last_event, input ready);
  modport sink (input valid, event_res, event_channel, raise_flag, still_running,
                last_event, output ready);
endinterface

FILE: src/mcdt_cell.sv
module mcdt_cell #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mcdt_pkg::cell_cmd_t    cmd,
  input  logic [COUNT_WIDTH-1:0] el,
  input  logic [COUNT_WIDTH-1:0] sum,
  input  logic                   hit,
  input  logic                   pend_clr,
  input  logic                   tok_in_valid,
  input  logic [COUNT_WIDTH-1:0] tok_in_best,
  output logic                   tok_out_valid,
  output logic [COUNT_WIDTH-1:0] tok_out_best,
  output mcdt_pkg::cell_stat_t   stat
);

  localparam logic [COUNT_WIDTH-1:0] IDLE = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] count;
  logic                   notify_mark;
  logic                   blocking_mark;
  logic                   pend;
  logic                   pend_block;
  logic                   pend_flag;

  logic [COUNT_WIDTH-1:0] pre;
  logic                   pre_nt;
  logic                   pre_bl;
  logic                   live;
  logic                   expire;
  logic [COUNT_WIDTH-1:0] rebased;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] best_next;

  always_comb begin
    pre    = count;
    pre_nt = notify_mark;
    pre_bl = blocking_mark;
    if (hit && cmd.mode == mcdt_pkg::CMD_START) begin
      pre    = sum;
      pre_nt = cmd.notify;
      pre_bl = cmd.blocking;
    end else if (hit && cmd.mode == mcdt_pkg::CMD_CANCEL) begin
      pre    = IDLE;
      pre_nt = 1'b0;
      pre_bl = 1'b0;
    end
    live    = (pre != IDLE);
    expire  = (cmd.mode == mcdt_pkg::CMD_EXPIRE) && live && (pre <= el);
    rebased = (pre < el) ? '0 : pre - el;
    count_next = (!live || expire) ? IDLE : rebased;
    // strict compare keeps the lowest channel on ties
    best_next = (count_next != IDLE && count_next < tok_in_best) ? count_next : tok_in_best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= IDLE;
      notify_mark   <= 1'b0;
      blocking_mark <= 1'b0;
      pend          <= 1'b0;
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= tok_in_valid;
      if (tok_in_valid) begin
        count         <= count_next;
        notify_mark   <= expire ? 1'b0 : pre_nt;
        blocking_mark <= expire ? 1'b0 : pre_bl;
      end
      if (tok_in_valid && expire) begin
        pend <= 1'b1;
      end else if (pend_clr) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in_valid) begin
      tok_out_best <= best_next;
    end
    if (tok_in_valid && expire) begin
      pend_block <= pre_bl;
      pend_flag  <= pre_nt;
    end
  end

  assign stat.live       = (count != IDLE);
  assign stat.blocking   = blocking_mark;
  assign stat.pend       = pend;
  assign stat.pend_block = pend_block;
  assign stat.pend_flag  = pend_flag;

endmodule

FILE: src/multi_channel_delta_delay_timer.sv
// chan | dir | fields
// req  | in  | operation channel delay_ms notify blocking
// evt  | out | event_res event_channel raise_flag still_running last_event
//
// a tick that does not reach the deadline, or arrives while idle, is absorbed in ST_IDLE
// start, cancel and an expiring tick pass through ST_PREP, ST_SCAN and ST_EMIT, where each
// event goes out in turn; the scan walks one cell per cycle
// a bad request goes to ST_EMIT for its one event; req.ready is high only between items
// rst is synchronous and clears every count to idle at once, no clearing pass
// evt.ready low holds the current event and stalls the remaining ones
module multi_channel_delta_delay_timer #(
  parameter int NUM_CHANNELS = 8,
  parameter int COUNT_WIDTH  = 16
) (
  input logic        clk,
  input logic        rst,
  mcdt_req_if.sink   req,
  mcdt_evt_if.source evt
);

  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SUM_W = ((COUNT_WIDTH > mcdt_pkg::DELAY_W) ? COUNT_WIDTH
                                                             : mcdt_pkg::DELAY_W) + 1;
  localparam logic [COUNT_WIDTH-1:0] IDLE    = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] SAT_MAX = {{(COUNT_WIDTH-1){1'b1}}, 1'b0};

  mcdt_pkg::state_t state, state_next;

  logic                        active;
  logic [COUNT_WIDTH-1:0]      ttd;
  logic [COUNT_WIDTH-1:0]      ncount;
  logic [COUNT_WIDTH-1:0]      el;
  logic [COUNT_WIDTH-1:0]      sum;
  logic [mcdt_pkg::DELAY_W-1:0] delay;
  mcdt_pkg::cmd_t              mode;
  logic [CH_W-1:0]             tgt;
  logic                        cmd_nt;
  logic                        cmd_bl;
  logic                        launch;
  logic                        single;
  logic [mcdt_pkg::RES_W-1:0]  single_res;
  logic [mcdt_pkg::CHAN_W-1:0] single_ch;

  logic                        evt_valid;
  logic [mcdt_pkg::RES_W-1:0]  evt_res;
  logic [mcdt_pkg::CHAN_W-1:0] evt_ch;
  logic                        evt_flag;
  logic                        evt_still;
  logic                        evt_last;

  mcdt_pkg::cell_cmd_t  cell_cmd;
  mcdt_pkg::cell_stat_t stat [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] tok_v;
  logic [COUNT_WIDTH-1:0]  tok_b [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] hit;
  logic [NUM_CHANNELS-1:0] pend_vec;
  logic [NUM_CHANNELS-1:0] block_vec;
  logic [NUM_CHANNELS-1:0] flag_vec;
  logic [NUM_CHANNELS-1:0] pend_clr;

  // request decode
  logic                   accept;
  logic                   in_range;
  logic [CH_W-1:0]        ch_idx;
  logic                   is_tick;
  logic                   start_ok;
  logic                   cancel_ok;
  logic [COUNT_WIDTH-1:0] tick_dec;
  logic                   tick_fire;
  logic [COUNT_WIDTH-1:0] el_now;
  logic [SUM_W-1:0]       sum_wide;
  logic [COUNT_WIDTH-1:0] sum_next;
  logic [COUNT_WIDTH-1:0] scan_best;

  // event selection
  logic [NUM_CHANNELS-1:0] low;
  logic [CH_W-1:0]         low_idx;
  logic                    low_block;
  logic                    low_flag;
  logic                    any_pend;
  logic                    last_pend;
  logic                    do_load;
  logic [mcdt_pkg::RES_W-1:0]  ev_res_next;
  logic [mcdt_pkg::CHAN_W-1:0] ev_ch_next;
  logic                        ev_flag_next;
  logic                        ev_last_next;

  assign cell_cmd.mode     = mode;
  assign cell_cmd.notify   = cmd_nt;
  assign cell_cmd.blocking = cmd_bl;

  genvar gi;
  generate
    for (gi = 0; gi < NUM_CHANNELS; gi++) begin : g_cell
      logic                   tin_v;
      logic [COUNT_WIDTH-1:0] tin_b;
      if (gi == 0) begin : g_head
        assign tin_v = launch;
        assign tin_b = IDLE;
      end else begin : g_link
        assign tin_v = tok_v[gi-1];
        assign tin_b = tok_b[gi-1];
      end
      assign hit[gi]       = (tgt == CH_W'(gi));
      assign pend_vec[gi]  = stat[gi].pend;
      assign block_vec[gi] = stat[gi].pend_block;
      assign flag_vec[gi]  = stat[gi].pend_flag;

      mcdt_cell #(
        .COUNT_WIDTH(COUNT_WIDTH)
      ) u_cell (
        .clk          (clk),
        .rst          (rst),
        .cmd          (cell_cmd),
        .el           (el),
        .sum          (sum),
        .hit          (hit[gi]),
        .pend_clr     (pend_clr[gi]),
        .tok_in_valid (tin_v),
        .tok_in_best  (tin_b),
        .tok_out_valid(tok_v[gi]),
        .tok_out_best (tok_b[gi]),
        .stat         (stat[gi])
      );
    end
  endgenerate

  assign scan_best = tok_b[NUM_CHANNELS-1];

  always_comb begin
    accept    = req.valid && (state == mcdt_pkg::ST_IDLE);
    in_range  = ({1'b0, req.channel} < (mcdt_pkg::CHAN_W + 1)'(NUM_CHANNELS));
    ch_idx    = req.channel[CH_W-1:0];
    is_tick   = (req.operation == mcdt_pkg::OP_TICK);
    start_ok  = (req.operation == mcdt_pkg::OP_START) && in_range && (req.delay_ms != '0);
    cancel_ok = (req.operation == mcdt_pkg::OP_CANCEL) && in_range;
    tick_dec  = (ttd == '0) ? '0 : ttd - 1'b1;
    tick_fire = active && (tick_dec == '0);
    el_now    = (active && ttd <= ncount) ? ncount - ttd : '0;
    sum_wide  = SUM_W'(delay) + SUM_W'(el);
    sum_next  = (sum_wide > SUM_W'(SAT_MAX)) ? SAT_MAX : sum_wide[COUNT_WIDTH-1:0];
  end

  // lowest pending channel goes out first
  always_comb begin
    low       = pend_vec & (~pend_vec + NUM_CHANNELS'(1));
    low_idx   = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (low[i]) begin
        low_idx = low_idx | CH_W'(i);
      end
    end
    low_block = |(low & block_vec);
    low_flag  = |(low & flag_vec);
    any_pend  = |pend_vec;
    last_pend = ((pend_vec & ~low) == '0);
  end

  always_comb begin
    state_next = state;
    case (state)
      mcdt_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_tick) begin
            state_next = tick_fire ? mcdt_pkg::ST_PREP : mcdt_pkg::ST_IDLE;
          end else if (start_ok || cancel_ok) begin
            state_next = mcdt_pkg::ST_PREP;
          end else begin
            state_next = mcdt_pkg::ST_EMIT;
          end
        end
      end
      mcdt_pkg::ST_PREP: begin
        state_next = mcdt_pkg::ST_SCAN;
      end
      mcdt_pkg::ST_SCAN: begin
        if (tok_v[NUM_CHANNELS-1]) begin
          state_next = mcdt_pkg::ST_EMIT;
        end
      end
      mcdt_pkg::ST_EMIT: begin
        if (!single && !any_pend) begin
          state_next = mcdt_pkg::ST_IDLE;
        end else if (do_load && (single || last_pend)) begin
          state_next = mcdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mcdt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req.ready    = (state == mcdt_pkg::ST_IDLE);
    do_load      = 1'b0;
    pend_clr     = '0;
    ev_res_next  = single_res;
    ev_ch_next   = single_ch;
    ev_flag_next = 1'b0;
    ev_last_next = 1'b1;
    if (state == mcdt_pkg::ST_EMIT && (!evt_valid || evt.ready)) begin
      if (single) begin
        do_load = 1'b1;
      end else if (any_pend) begin
        do_load      = 1'b1;
        pend_clr     = low;
        ev_res_next  = low_block ? mcdt_pkg::EV_BLOCK_REL : mcdt_pkg::EV_EXPIRED;
        ev_ch_next   = mcdt_pkg::CHAN_W'(low_idx);
        ev_flag_next = low_flag;
        ev_last_next = last_pend;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mcdt_pkg::ST_IDLE;
      active    <= 1'b0;
      ttd       <= '0;
      launch    <= 1'b0;
      single    <= 1'b0;
      evt_valid <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= (state == mcdt_pkg::ST_PREP);
      if (accept) begin
        if (is_tick) begin
          single <= 1'b0;
          if (active) begin
            ttd <= tick_dec;
          end
        end else if (start_ok) begin
          single <= req.blocking;
        end else if (cancel_ok) begin
          single <= stat[ch_idx].live && stat[ch_idx].blocking;
        end else begin
          single <= 1'b1;
        end
      end
      if (state == mcdt_pkg::ST_SCAN && tok_v[NUM_CHANNELS-1]) begin
        active <= (scan_best != IDLE);
        ttd    <= (scan_best != IDLE) ? scan_best : '0;
      end
      if (do_load) begin
        evt_valid <= 1'b1;
        if (single) begin
          single <= 1'b0;
        end
      end else if (evt.ready) begin
        evt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      delay      <= req.delay_ms;
      tgt        <= ch_idx;
      cmd_nt     <= req.notify;
      cmd_bl     <= req.blocking;
      single_ch  <= req.channel;
      if (is_tick) begin
        mode <= mcdt_pkg::CMD_EXPIRE;
        el   <= ncount;
      end else if (start_ok) begin
        mode       <= mcdt_pkg::CMD_START;
        el         <= el_now;
        single_res <= mcdt_pkg::EV_BLOCK_REQ;
      end else if (cancel_ok) begin
        mode       <= mcdt_pkg::CMD_CANCEL;
        el         <= el_now;
        single_res <= mcdt_pkg::EV_BLOCK_REL;
      end else begin
        single_res <= mcdt_pkg::EV_BAD;
      end
    end
    if (state == mcdt_pkg::ST_PREP) begin
      sum <= sum_next;
    end
    if (state == mcdt_pkg::ST_SCAN && tok_v[NUM_CHANNELS-1]) begin
      ncount <= scan_best;
    end
    if (do_load) begin
      evt_res   <= ev_res_next;
      evt_ch    <= ev_ch_next;
      evt_flag  <= ev_flag_next;
      evt_still <= active;
      evt_last  <= ev_last_next;
    end
  end

  assign evt.valid         = evt_valid;
  assign evt.event_res     = evt_res;
  assign evt.event_channel = evt_ch;
  assign evt.raise_flag    = evt_flag;
  assign evt.still_running = evt_still;
  assign evt.last_event    = evt_last;

`ifndef NO_ASSERTIONS
  a_ttd_bound: assert property (@(posedge clk) disable iff (rst)
    active |-> ttd <= ncount)
    else $error("countdown exceeds nearest count");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !active |-> ttd == '0)
    else $error("countdown nonzero while stopped");

  a_one_wave: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_v))
    else $error("more than one scan wave in the cell row");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (rst)
    state == mcdt_pkg::ST_IDLE |-> pend_vec == '0)
    else $error("expiry left unreported between words");
`endif

endmodule
